FILE: design/lli_pkg.sv
// Shared types and constants for the 2D line-line intersection block.
// No dependencies.
`default_nettype none
package lli_pkg;

  localparam int CoordWidth  = 32;
  localparam int DirWidth    = 16;
  localparam int DirFrac     = 14;
  localparam int ThreshWidth = 29;
  localparam int DenWidth    = 32;
  localparam int NumWidth    = 63;  // |num| << DirFrac
  localparam int QuoWidth    = 49;  // quotient after clamp to 2^48
  localparam int DivStages   = NumWidth;
  localparam logic [ThreshWidth-1:0] ThreshReset = 29'd268;

  typedef struct packed {
    logic signed [CoordWidth-1:0] first_point_x;
    logic signed [CoordWidth-1:0] first_point_y;
    logic signed [DirWidth-1:0]   first_dir_x;
    logic signed [DirWidth-1:0]   first_dir_y;
    logic signed [CoordWidth-1:0] second_point_x;
    logic signed [CoordWidth-1:0] second_point_y;
    logic signed [DirWidth-1:0]   second_dir_x;
    logic signed [DirWidth-1:0]   second_dir_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] cross_x;
    logic signed [CoordWidth-1:0] cross_y;
    logic [CoordWidth-1:0]        along_distance;
    logic                         is_parallel;
  } out_item_t;

  typedef struct packed {
    logic                         parallel;
    logic                         flip;
    logic [DenWidth-1:0]          den;
    logic [NumWidth-1:0]          num;
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] py;
    logic signed [DirWidth-1:0]   rx;
    logic signed [DirWidth-1:0]   ry;
  } job_t;

endpackage
`default_nettype wire

FILE: design/line_line_intersection_2d.sv
// 2D line-line intersection, fixed point. Accepts one item per cycle; busy never
// rises since the divider pipeline never stalls. An accepted item goes through
// the front stages, the queue, 63 divider stages and 2 output stages; then done rises.
// Results appear for one cycle on done; the receiver cannot stall.
// Synchronous active-high reset empties the pipeline and sets the
// parallel threshold to 268.
`default_nettype none
module line_line_intersection_2d (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire lli_pkg::in_item_t  item,
  output logic                    done,
  output lli_pkg::out_item_t      result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [2:0] AddrThresh = 3'd0;

  logic [lli_pkg::ThreshWidth-1:0] threshold;
  logic          fv, qv, afull;
  lli_pkg::job_t fjob, qjob;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrThresh) ? {3'b0, threshold} : '0;
  assign busy   = afull;

  always_ff @(posedge clk) begin
    if (rst) threshold <= lli_pkg::ThreshReset;
    else if (psel && penable && pwrite && paddr == AddrThresh)
      threshold <= pwdata[lli_pkg::ThreshWidth-1:0];
  end

  lli_front u_front (
    .clk, .rst, .take(start && !busy), .item, .threshold,
    .job_valid(fv), .job(fjob)
  );

  lli_queue u_queue (
    .clk, .rst, .push(fv), .push_job(fjob),
    .pop_valid(qv), .pop_job(qjob), .afull
  );

  lli_back u_back (
    .clk, .rst, .job_valid(qv), .job(qjob), .done, .result
  );

endmodule
`default_nettype wire

FILE: design/lli_front.sv
// Front end: takes items, forms cross products and classifies parallel lines.
// Depends on lli_pkg.
`default_nettype none
module lli_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  take,
  input  wire lli_pkg::in_item_t                     item,
  input  wire logic [lli_pkg::ThreshWidth-1:0]       threshold,
  output logic                                       job_valid,
  output lli_pkg::job_t                              job
);

  logic                   v1, v2, v3;
  lli_pkg::in_item_t      it1;
  logic signed [31:0]     pa, pb;
  logic signed [32:0]     dx, dy;
  logic signed [32:0]     d2;
  logic signed [48:0]     na, nb;
  logic signed [31:0]     px2, py2, px3, py3;
  logic signed [15:0]     rx2, ry2, rx3, ry3;
  logic signed [15:0]     sy1, sx1;

  logic signed [49:0]     num;
  logic [31:0]            dmag;
  logic [48:0]            nmag;
  lli_pkg::job_t          job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      job_valid <= v3;
    end
    it1 <= item;
    pa  <= it1.first_dir_x * it1.second_dir_y;
    pb  <= it1.first_dir_y * it1.second_dir_x;
    dx  <= 33'(it1.second_point_x) - 33'(it1.first_point_x);
    dy  <= 33'(it1.second_point_y) - 33'(it1.first_point_y);
    // second-line directions travel with dx/dy into the product stage
    sy1 <= it1.second_dir_y;
    sx1 <= it1.second_dir_x;
    px2 <= it1.first_point_x;
    py2 <= it1.first_point_y;
    rx2 <= it1.first_dir_x;
    ry2 <= it1.first_dir_y;
    d2  <= 33'(pa) - 33'(pb);
    na  <= dx * 49'(sy1);
    nb  <= 49'(sx1) * dy;
    px3 <= px2;
    py3 <= py2;
    rx3 <= rx2;
    ry3 <= ry2;
    job <= job_next;
  end

  always_comb begin
    num  = 50'(na) - 50'(nb);
    dmag = d2[32] ? 32'(-d2) : d2[31:0];
    nmag = num[49] ? 49'(-num) : num[48:0];
    job_next.parallel = (dmag == '0) || (dmag < {3'b0, threshold});
    job_next.flip     = num[49] != d2[32];
    job_next.den      = dmag;
    job_next.num      = {nmag, {lli_pkg::DirFrac{1'b0}}};
    job_next.px       = px3;
    job_next.py       = py3;
    job_next.rx       = rx3;
    job_next.ry       = ry3;
  end

endmodule
`default_nettype wire

FILE: design/lli_queue.sv
// Small FIFO of classified jobs between the front end and the divider.
// Depends on lli_pkg.
`default_nettype none
module lli_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lli_pkg::job_t push_job,
  output logic               pop_valid,
  output lli_pkg::job_t      pop_job,
  output logic               afull
);

  lli_pkg::job_t mem [0:7];
  logic [2:0]    wp, rp;
  logic [3:0]    count;
  logic          pop;

  // back end never stalls, so the head leaves every cycle it is present
  assign pop       = count != '0;
  assign afull     = count >= 4'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
      pop_valid <= 1'b0;
    end else begin
      if (push) wp <= wp + 3'd1;
      if (pop) rp <= rp + 3'd1;
      count <= count + {3'b0, push} - {3'b0, pop};
      pop_valid <= pop;
    end
    if (push) mem[wp] <= push_job;
    pop_job <= mem[rp];
  end

endmodule
`default_nettype wire

FILE: design/lli_back.sv
// Back end: pipelined restoring divider, clamp, scale by direction, saturate.
// Depends on lli_pkg.
`default_nettype none
module lli_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  input  wire lli_pkg::job_t job,
  output logic               done,
  output lli_pkg::out_item_t result
);

  localparam int S = lli_pkg::DivStages;

  logic          dv_valid [1:S];
  lli_pkg::job_t dv       [1:S];
  logic [31:0]   rem      [1:S];

  // one quotient bit per stage; quotient bits shift into num from the bottom
  for (genvar k = 0; k < S; k++) begin : g_div
    logic          cv;
    lli_pkg::job_t cur;
    logic [31:0]   crem;
    logic [32:0]   rsh;
    logic          ge;
    lli_pkg::job_t nxt;
    if (k == 0) begin : g_first
      assign cv   = job_valid;
      assign cur  = job;
      assign crem = '0;
    end else begin : g_next
      assign cv   = dv_valid[k];
      assign cur  = dv[k];
      assign crem = rem[k];
    end
    always_comb begin
      rsh = {crem, cur.num[lli_pkg::NumWidth-1]};
      ge  = rsh >= {1'b0, cur.den};
      nxt = cur;
      nxt.num = {cur.num[lli_pkg::NumWidth-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) dv_valid[k+1] <= 1'b0;
      else dv_valid[k+1] <= cv;
      dv[k+1]  <= nxt;
      rem[k+1] <= ge ? 32'(rsh - {1'b0, cur.den}) : rsh[31:0];
    end
  end

  localparam logic [lli_pkg::NumWidth-1:0] QLim = 63'd1 << 48;

  logic [48:0] q;
  logic [15:0] arx, ary;
  assign q   = (dv[S].num > QLim) ? 49'(QLim) : dv[S].num[48:0];
  assign arx = dv[S].rx[15] ? 16'(-dv[S].rx) : dv[S].rx;
  assign ary = dv[S].ry[15] ? 16'(-dv[S].ry) : dv[S].ry;

  logic        mv, mpar, mnx, mny;
  logic [64:0] mx, my;
  logic [31:0] malong;
  logic signed [31:0] mpx, mpy;

  always_ff @(posedge clk) begin
    if (rst) mv <= 1'b0;
    else mv <= dv_valid[S];
    mx     <= q * 65'(arx);
    my     <= q * 65'(ary);
    mnx    <= dv[S].flip != dv[S].rx[15];
    mny    <= dv[S].flip != dv[S].ry[15];
    mpar   <= dv[S].parallel;
    malong <= (q > 49'h0_FFFF_FFFF) ? '1 : q[31:0];
    mpx    <= dv[S].px;
    mpy    <= dv[S].py;
  end

  function automatic logic signed [31:0] axis_sat(input logic [64:0] m, input logic neg,
                                                  input logic signed [31:0] p);
    logic signed [65:0] sv;
    logic signed [51:0] sh;
    logic signed [52:0] t;
    sv = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    sv = sv + 66'sd8192;
    sh = 52'(sv >>> lli_pkg::DirFrac);
    t  = 53'(sh) + 53'(p);
    if (t > 53'sh7FFF_FFFF) axis_sat = 32'sh7FFF_FFFF;
    else if (t < -53'sh8000_0000) axis_sat = 32'sh8000_0000;
    else axis_sat = t[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= mv;
    if (mpar) begin
      result.cross_x        <= 32'sh7FFF_FFFF;
      result.cross_y        <= 32'sh7FFF_FFFF;
      result.along_distance <= '1;
      result.is_parallel    <= 1'b1;
    end else begin
      result.cross_x        <= axis_sat(mx, mnx, mpx);
      result.cross_y        <= axis_sat(my, mny, mpy);
      result.along_distance <= malong;
      result.is_parallel    <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for line_line_intersection_2d: directed and random line
// pairs, APB threshold writes, per-field comparison against a local predictor.
// Depends on lli_pkg and the design top.
`timescale 1ns / 1ps
module tb;

  localparam int Latency = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lli_pkg::in_item_t item = '0;
  logic done;
  lli_pkg::out_item_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lli_pkg::out_item_t expected_q[$];
  logic [lli_pkg::ThreshWidth-1:0] thresh_model;
  int errors = 0;
  int idle_pct = 0;

  always #1 clk = ~clk;

  line_line_intersection_2d dut (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // point + a*dir, rounded then saturated to the coordinate width
  function automatic logic signed [lli_pkg::CoordWidth-1:0] axis_value(
      logic signed [lli_pkg::CoordWidth-1:0] p, logic [48:0] amag, bit aneg,
      logic signed [lli_pkg::DirWidth-1:0] dir);
    logic signed [127:0] prod;
    prod = $signed({79'd0, amag}) * $signed({{112{dir[lli_pkg::DirWidth-1]}}, dir});
    if (aneg) prod = -prod;
    prod = (prod + (128'sd1 <<< (lli_pkg::DirFrac - 1))) >>> lli_pkg::DirFrac;
    prod = prod + $signed({{96{p[lli_pkg::CoordWidth-1]}}, p});
    if (prod < -128'sd2147483648) return 32'sh80000000;
    if (prod > 128'sd2147483647) return 32'sh7fffffff;
    return prod[31:0];
  endfunction

  function automatic lli_pkg::out_item_t predict_intersection(lli_pkg::in_item_t it);
    lli_pkg::out_item_t o;
    logic signed [63:0] d, dx, dy;
    logic [63:0] dmag;
    logic signed [127:0] num;
    logic [127:0] nmag, quo;
    bit flip;
    d = 64'(it.first_dir_x) * 64'(it.second_dir_y) - 64'(it.first_dir_y) * 64'(it.second_dir_x);
    dmag = d < 0 ? -d : d;
    if (dmag == 0 || dmag < 64'(thresh_model)) begin
      o.cross_x = 32'sh7fffffff;
      o.cross_y = 32'sh7fffffff;
      o.along_distance = '1;
      o.is_parallel = 1'b1;
      return o;
    end
    dx = 64'(it.second_point_x) - 64'(it.first_point_x);
    dy = 64'(it.second_point_y) - 64'(it.first_point_y);
    num = 128'(dx) * 128'(it.second_dir_y) - 128'(it.second_dir_x) * 128'(dy);
    flip = (num < 0) != (d < 0);
    nmag = num < 0 ? -num : num;
    quo = (nmag << lli_pkg::DirFrac) / {64'd0, dmag};
    if (quo > (128'd1 << 48)) quo = 128'd1 << 48;
    o.cross_x = axis_value(it.first_point_x, quo[48:0], flip, it.first_dir_x);
    o.cross_y = axis_value(it.first_point_y, quo[48:0], flip, it.first_dir_y);
    o.along_distance = quo > 128'hffffffff ? '1 : quo[31:0];
    o.is_parallel = 1'b0;
    return o;
  endfunction

  always @(posedge clk) begin
    lli_pkg::out_item_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.cross_x !== e.cross_x)
          $display("%0t: cross_x exp %h got %h", $time, e.cross_x, result.cross_x);
        if (result.cross_y !== e.cross_y)
          $display("%0t: cross_y exp %h got %h", $time, e.cross_y, result.cross_y);
        if (result.along_distance !== e.along_distance)
          $display("%0t: along_distance exp %h got %h", $time, e.along_distance,
                   result.along_distance);
        if (result.is_parallel !== e.is_parallel)
          $display("%0t: is_parallel exp %b got %b", $time, e.is_parallel,
                   result.is_parallel);
        if (result !== e) errors++;
      end
    end
  end

  // start stays high between back-to-back transfers; it drops while idling or draining
  task automatic send_lines(lli_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_intersection(it));
    @(negedge clk);
  endtask

  task automatic drain;
    int guard = 0;
    start <= 1'b0;
    while (expected_q.size() != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (Latency) @(negedge clk);
  endtask

  task automatic write_threshold(logic [lli_pkg::ThreshWidth-1:0] v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thresh_model = v;
  endtask

  function automatic logic signed [lli_pkg::DirWidth-1:0] rand_dir();
    case ($urandom_range(3))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return lli_pkg::DirWidth'($signed($urandom_range(32768)) - 16384);
      default: return lli_pkg::DirWidth'($urandom);
    endcase
  endfunction

  function automatic lli_pkg::in_item_t rand_lines();
    lli_pkg::in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      it.first_point_x = $signed(it.first_point_x) >>> $urandom_range(20);
      it.first_point_y = $signed(it.first_point_y) >>> $urandom_range(20);
      it.second_point_x = $signed(it.second_point_x) >>> $urandom_range(20);
      it.second_point_y = $signed(it.second_point_y) >>> $urandom_range(20);
    end
    it.first_dir_x = rand_dir(); it.first_dir_y = rand_dir();
    it.second_dir_x = rand_dir(); it.second_dir_y = rand_dir();
    // near-parallel pairs
    if ($urandom_range(5) == 0) begin
      it.second_dir_x = it.first_dir_x + lli_pkg::DirWidth'($signed($urandom_range(6)) - 3);
      it.second_dir_y = it.first_dir_y;
    end
    return it;
  endfunction

  task automatic test_directed;
    lli_pkg::in_item_t it;
    it = '0;
    it.first_dir_x = 16'sd16384; it.second_dir_y = 16'sd16384;
    send_lines(it);                                   // axis-aligned crossing at origin
    it.second_point_x = 32'sh00050000; it.first_point_y = 32'sh00030000;
    send_lines(it);
    it.second_dir_x = 16'sd16384; it.second_dir_y = 0;
    send_lines(it);                                   // zero cross product
    it.first_point_x = 32'sh7fffffff; it.second_point_x = 32'sh80000000;
    it.first_dir_x = 1; it.first_dir_y = 0; it.second_dir_x = 0; it.second_dir_y = 1;
    send_lines(it);                                   // tiny cross product, huge parameter
    it = '1;
    send_lines(it);
    it = {32'sh80000000, 32'sh7fffffff, -16'sd16384, 16'sd16384,
          32'sh7fffffff, 32'sh80000000, 16'sd16384, 16'sd16384};
    send_lines(it);                                   // saturating coordinates
    it.first_dir_x = 16'sh7fff; it.first_dir_y = 16'sh8000;  // non-unit extremes
    it.second_dir_x = 16'sh8000; it.second_dir_y = 16'sh7fff;
    send_lines(it);
    it = '0;
    it.first_dir_x = 16'sd11585; it.first_dir_y = 16'sd11585;
    it.second_dir_x = -16'sd11585; it.second_dir_y = 16'sd11585;
    it.second_point_x = 32'sh00010001; it.second_point_y = 32'shfffeffff;
    send_lines(it);                                   // rounding of a*R
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    repeat (n) send_lines(rand_lines());
    idle_pct = 0;
  endtask

  task automatic test_thresholds;
    logic [lli_pkg::ThreshWidth-1:0] vals[5] =
        '{29'd0, 29'd268435456, 29'd1, 29'd268, 29'h1fffffff};
    foreach (vals[i]) begin
      write_threshold(vals[i]);
      test_random(40, (i % 2) ? 67 : 11);
    end
    write_threshold(29'($urandom_range(20000)));
    test_random(40, 0);
  endtask

  initial begin
    thresh_model = lli_pkg::ThreshReset;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(150, 0);
    test_random(150, 67);
    test_random(100, 11);
    test_thresholds();
    drain();
    if (errors == 0 && expected_q.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
